### rtl/core/dsk_pkg.sv
// shared types for the data stack cell chain
`timescale 1ns / 1ps

package dsk_pkg;

  // what the whole chain does as one operation
  typedef enum logic [2:0] {
    CH_HOLD    = 3'd0,
    CH_PUSH    = 3'd1,
    CH_POP     = 3'd2,
    CH_DUP     = 3'd3,
    CH_SWAP    = 3'd4,
    CH_ROT     = 3'd5,
    CH_RESTORE = 3'd6
  } dsk_chain_op_t;

  // what one cell loads
  typedef enum logic [1:0] {
    CELL_HOLD       = 2'd0,
    CELL_FROM_ABOVE = 2'd1,
    CELL_FROM_BELOW = 2'd2,
    CELL_LOAD       = 2'd3
  } dsk_cell_sel_t;

endpackage

### rtl/core/dsk_cell.sv
// one stack cell: a word register fed by its neighbors or a direct load
`timescale 1ns / 1ps

module dsk_cell
  import dsk_pkg::*;
#(
  parameter int W = 32
) (
  input  logic          clk,
  input  dsk_cell_sel_t sel_i,
  input  logic [W-1:0]  above_i,
  input  logic [W-1:0]  below_i,
  input  logic [W-1:0]  load_i,
  output logic [W-1:0]  data_o
);

  logic [W-1:0] data_r;
  logic [W-1:0] data_nxt;

  always_comb begin
    unique case (sel_i)
      CELL_FROM_ABOVE: data_nxt = above_i;
      CELL_FROM_BELOW: data_nxt = below_i;
      CELL_LOAD:       data_nxt = load_i;
      default:         data_nxt = data_r;
    endcase
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data_o = data_r;

endmodule

### rtl/core/dsk_chain.sv
// row of stack cells, cell 0 on top, closed into a ring for scans
`timescale 1ns / 1ps

module dsk_chain
  import dsk_pkg::*;
#(
  parameter int DEPTH = 256,
  parameter int W     = 32
) (
  input  logic          clk,
  input  dsk_chain_op_t op_i,
  input  logic [W-1:0]  push_i,
  output logic [W-1:0]  top_o
);

  logic [W-1:0]  w   [DEPTH];
  dsk_cell_sel_t sel [DEPTH];
  logic [W-1:0]  head;

  // restore turns the ring downward: bottom word wraps to the top
  assign head = (op_i == CH_RESTORE) ? w[DEPTH-1] : push_i;

  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      unique case (op_i) inside
        CH_PUSH, CH_RESTORE: sel[i] = CELL_FROM_ABOVE;
        CH_POP:              sel[i] = CELL_FROM_BELOW;
        CH_DUP:              sel[i] = (i == 0) ? CELL_HOLD : CELL_FROM_ABOVE;
        CH_SWAP:             sel[i] = (i < 2) ? CELL_LOAD : CELL_HOLD;
        CH_ROT:              sel[i] = (i < 3) ? CELL_LOAD : CELL_HOLD;
        default:             sel[i] = CELL_HOLD;
      endcase
    end
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [W-1:0] above;
    logic [W-1:0] below;
    logic [W-1:0] ld;

    if (i == 0) begin : g_top
      assign above = head;
      assign ld    = (op_i == CH_SWAP) ? w[1] : w[2];
    end else begin : g_mid
      assign above = w[i-1];
      if (i == 1) begin : g_one
        assign ld = w[0];
      end else if (i == 2) begin : g_two
        assign ld = w[1];
      end else begin : g_rest
        assign ld = w[i];
      end
    end

    // pop and scan wrap the top word into the bottom cell
    if (i == DEPTH - 1) begin : g_bot
      assign below = w[0];
    end else begin : g_nbot
      assign below = w[i+1];
    end

    dsk_cell #(
      .W(W)
    ) u_cell (
      .clk     (clk),
      .sel_i   (sel[i]),
      .above_i (above),
      .below_i (below),
      .load_i  (ld),
      .data_o  (w[i])
    );
  end

  assign top_o = w[0];

endmodule

### rtl/core/data_stack_with_dup_swap_rot_core.sv
// data stack with push, pop, dup, swap, rot and peek on a chain of cells
`timescale 1ns / 1ps
//
// channel   ports                                       transfer when
// --------  ------------------------------------------  -------------------
// command   start, busy, in_func, in_value, in_offset   start & !busy
// result    out_valid, out_read_value, out_count,       out_valid (one cycle)
//           out_error
//
// - push, pop, dup, swap, rot, unused function codes, failed ops and peek at
//   offset 0: the result strobes the cycle after the command transfer, busy stays low
// - peek at offset k > 0 keeps busy high while the cell ring turns up one place
//   per cycle until the word sits in the top cell, then turns back
// - the result of such a peek is registered once the word sits in the top cell
// - synchronous active-low reset empties the stack; cell contents are not
//   cleared, only words below the count are ever read
// - the receiver cannot stall: each result is shown for exactly one cycle

module data_stack_with_dup_swap_rot_core
  import dsk_pkg::*;
#(
  parameter int STACK_DEPTH = 256,
  parameter int DATA_WIDTH  = 32,
  localparam int CNT_W      = $clog2(STACK_DEPTH + 1)
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  output logic             busy,
  input  logic [2:0]       in_func,
  input  logic [31:0]      in_value,
  input  logic [7:0]       in_offset,
  output logic             out_valid,
  output logic [31:0]      out_read_value,
  output logic [CNT_W-1:0] out_count,
  output logic [1:0]       out_error
);

  // cell width: the data ports carry at most 32 bits
  localparam int CW    = (DATA_WIDTH < 32) ? DATA_WIDTH : 32;
  localparam int CMP_W = (CNT_W > 8) ? CNT_W : 8;

  typedef enum logic [2:0] {
    OP_PUSH = 3'd0,
    OP_POP  = 3'd1,
    OP_DUP  = 3'd2,
    OP_SWAP = 3'd3,
    OP_ROT  = 3'd4,
    OP_PEEK = 3'd5
  } op_t;

  typedef enum logic [1:0] {
    ERR_OK    = 2'd0,
    ERR_UNDER = 2'd1,
    ERR_OVER  = 2'd2
  } err_t;

  typedef enum logic [2:0] {
    ST_IDLE    = 3'b001,
    ST_SCAN    = 3'b010,
    ST_RESTORE = 3'b100
  } state_t;

  state_t            state_r, state_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [7:0]        cnt_r, cnt_nxt;      // ring turns left in this phase
  logic [7:0]        steps_r, steps_nxt;  // peek offset, turns to undo
  logic              out_valid_r, out_valid_nxt;
  logic [31:0]       rd_r, rd_nxt;
  logic [CNT_W-1:0]  out_count_r, out_count_nxt;
  err_t              err_r, err_nxt;

  dsk_chain_op_t     chain_op;
  logic [CW-1:0]     top;
  logic              accept;
  logic              empty, full;
  logic [CMP_W-1:0]  off_x, cnt_x;

  dsk_chain #(
    .DEPTH (STACK_DEPTH),
    .W     (CW)
  ) u_chain (
    .clk    (clk),
    .op_i   (chain_op),
    .push_i (in_value[CW-1:0]),
    .top_o  (top)
  );

  assign busy   = (state_r != ST_IDLE);
  assign accept = start && !busy;
  assign empty  = (count_r == '0);
  assign full   = (count_r == CNT_W'(STACK_DEPTH));
  assign off_x  = CMP_W'(in_offset);
  assign cnt_x  = CMP_W'(count_r);

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    cnt_nxt       = cnt_r;
    steps_nxt     = steps_r;
    out_valid_nxt = 1'b0;
    rd_nxt        = '0;
    out_count_nxt = count_r;
    err_nxt       = ERR_OK;
    chain_op      = CH_HOLD;

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          out_valid_nxt = 1'b1;
          unique case (in_func)
            OP_PUSH: begin
              if (full) begin
                err_nxt = ERR_OVER;
              end else begin
                chain_op  = CH_PUSH;
                count_nxt = count_r + 1'b1;
              end
            end
            OP_POP: begin
              if (empty) begin
                err_nxt = ERR_UNDER;
              end else begin
                chain_op  = CH_POP;
                rd_nxt    = 32'(top);
                count_nxt = count_r - 1'b1;
              end
            end
            OP_DUP: begin
              if (empty) begin
                err_nxt = ERR_UNDER;
              end else if (full) begin
                err_nxt = ERR_OVER;
              end else begin
                chain_op  = CH_DUP;
                count_nxt = count_r + 1'b1;
              end
            end
            OP_SWAP: begin
              if (count_r < CNT_W'(2)) begin
                err_nxt = ERR_UNDER;
              end else begin
                chain_op = CH_SWAP;
              end
            end
            OP_ROT: begin
              if (count_r < CNT_W'(3)) begin
                err_nxt = ERR_UNDER;
              end else begin
                chain_op = CH_ROT;
              end
            end
            OP_PEEK: begin
              if (off_x >= cnt_x) begin
                err_nxt = ERR_UNDER;
              end else if (in_offset == 8'd0) begin
                rd_nxt = 32'(top);
              end else begin
                // start turning the ring; result comes once the word is on top
                out_valid_nxt = 1'b0;
                chain_op      = CH_POP;
                cnt_nxt       = in_offset - 8'd1;
                steps_nxt     = in_offset;
                state_nxt     = ST_SCAN;
              end
            end
            default: ;
          endcase
          out_count_nxt = count_nxt;
        end
      end
      ST_SCAN: begin
        if (cnt_r != 8'd0) begin
          chain_op = CH_POP;
          cnt_nxt  = cnt_r - 8'd1;
        end else begin
          out_valid_nxt = 1'b1;
          rd_nxt        = 32'(top);
          chain_op      = CH_RESTORE;
          if (steps_r == 8'd1) begin
            state_nxt = ST_IDLE;
          end else begin
            cnt_nxt   = steps_r - 8'd1;
            state_nxt = ST_RESTORE;
          end
        end
      end
      ST_RESTORE: begin
        chain_op = CH_RESTORE;
        if (cnt_r == 8'd1) begin
          state_nxt = ST_IDLE;
        end else begin
          cnt_nxt = cnt_r - 8'd1;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload and counters without reset
  always_ff @(posedge clk) begin
    cnt_r       <= cnt_nxt;
    steps_r     <= steps_nxt;
    rd_r        <= rd_nxt;
    out_count_r <= out_count_nxt;
    err_r       <= err_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_read_value = rd_r;
  assign out_count      = out_count_r;
  assign out_error      = err_r;

endmodule

### sim/tb_data_stack_with_dup_swap_rot_core.sv
// testbench for the data stack core: directed command table, then random command phases
`timescale 1ns / 1ps

module tb_data_stack_with_dup_swap_rot_core;

  localparam int DEPTH        = 256;
  localparam int CNT_W        = 9;
  localparam int NUM_RANDOM   = 900;
  localparam int CYCLE_LIMIT  = 5_000_000;
  // a peek at offset 255 holds busy longest, so leave a bit more at the end
  localparam int SETTLE_CYCLES = 520;
  localparam int MAX_REPORTS  = 10;

  typedef enum logic [2:0] {
    FN_PUSH = 3'd0,
    FN_POP  = 3'd1,
    FN_DUP  = 3'd2,
    FN_SWAP = 3'd3,
    FN_ROT  = 3'd4,
    FN_PEEK = 3'd5,
    FN_NOP6 = 3'd6,
    FN_NOP7 = 3'd7
  } stack_func_t;

  typedef enum logic [1:0] {
    ERR_OK    = 2'd0,
    ERR_UNDER = 2'd1,
    ERR_OVER  = 2'd2
  } stack_err_t;

  // bias of a random phase
  typedef enum logic [1:0] {
    MODE_FILL,
    MODE_DRAIN,
    MODE_MIXED
  } phase_mode_t;

  typedef struct packed {
    logic [31:0]      read_value;
    logic [CNT_W-1:0] count;
    logic [1:0]       error;
  } stack_result_t;

  // one directed command; typed rows carry their expected result, the rest use the predictor
  typedef struct packed {
    stack_func_t   func;
    logic [31:0]   value;
    logic [7:0]    offset;
    logic          typed;
    stack_result_t want;
  } stack_row_t;

  logic             clk = 1'b0;
  logic             rst_n;
  logic             start;
  logic             busy;
  logic [2:0]       in_func;
  logic [31:0]      in_value;
  logic [7:0]       in_offset;
  logic             out_valid;
  logic [31:0]      out_read_value;
  logic [CNT_W-1:0] out_count;
  logic [1:0]       out_error;

  data_stack_with_dup_swap_rot_core #(
    .STACK_DEPTH(DEPTH),
    .DATA_WIDTH (32)
  ) dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_func       (in_func),
    .in_value      (in_value),
    .in_offset     (in_offset),
    .out_valid     (out_valid),
    .out_read_value(out_read_value),
    .out_count     (out_count),
    .out_error     (out_error)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // shadow copy of the stack, updated at each command transfer
  logic [31:0]   shadow_stack [DEPTH];
  int unsigned   shadow_depth = 0;
  stack_result_t pending_stack_results [$];

  int unsigned cycle_count = 0;
  int unsigned mismatches = 0;
  int unsigned results_seen = 0;
  int unsigned func_count [8];
  int unsigned err_count [4];
  int unsigned deepest = 0;

  // after reset: every op that fails on an empty stack, then a small stack worked through each op
  stack_row_t reset_rows [21] = '{
    '{FN_POP,  32'h0,         8'd0,   1'b1, '{32'h0, 9'd0, ERR_UNDER}},
    '{FN_DUP,  32'h0,         8'd0,   1'b1, '{32'h0, 9'd0, ERR_UNDER}},
    '{FN_SWAP, 32'h0,         8'd0,   1'b1, '{32'h0, 9'd0, ERR_UNDER}},
    '{FN_ROT,  32'h0,         8'd0,   1'b1, '{32'h0, 9'd0, ERR_UNDER}},
    '{FN_PEEK, 32'h0,         8'd0,   1'b1, '{32'h0, 9'd0, ERR_UNDER}},
    '{FN_PUSH, 32'hFFFF_FFFF, 8'd0,   1'b1, '{32'h0, 9'd1, ERR_OK}},
    '{FN_SWAP, 32'h0,         8'd0,   1'b1, '{32'h0, 9'd1, ERR_UNDER}},
    '{FN_DUP,  32'h0,         8'd0,   1'b1, '{32'h0, 9'd2, ERR_OK}},
    '{FN_ROT,  32'h0,         8'd0,   1'b1, '{32'h0, 9'd2, ERR_UNDER}},
    '{FN_PUSH, 32'h0,         8'd0,   1'b1, '{32'h0, 9'd3, ERR_OK}},
    '{FN_PUSH, 32'hA5A5_5A5A, 8'd0,   1'b1, '{32'h0, 9'd4, ERR_OK}},
    '{FN_ROT,  32'h0,         8'd0,   1'b0, '0},
    '{FN_SWAP, 32'h0,         8'd0,   1'b0, '0},
    '{FN_PEEK, 32'h0,         8'd3,   1'b0, '0},
    '{FN_PEEK, 32'h0,         8'd4,   1'b1, '{32'h0, 9'd4, ERR_UNDER}},
    '{FN_PEEK, 32'h0,         8'd255, 1'b1, '{32'h0, 9'd4, ERR_UNDER}},
    '{FN_NOP6, 32'hFFFF_FFFF, 8'd255, 1'b1, '{32'h0, 9'd4, ERR_OK}},
    '{FN_POP,  32'h0,         8'd0,   1'b0, '0},
    '{FN_POP,  32'h0,         8'd0,   1'b0, '0},
    '{FN_POP,  32'h0,         8'd0,   1'b0, '0},
    '{FN_POP,  32'h0,         8'd0,   1'b0, '0}
  };

  // with the stack full: overflow on push and dup, deepest peek
  stack_row_t full_rows [6] = '{
    '{FN_PUSH, 32'h1234_5678, 8'd0,   1'b1, '{32'h0, 9'd256, ERR_OVER}},
    '{FN_DUP,  32'h0,         8'd0,   1'b1, '{32'h0, 9'd256, ERR_OVER}},
    '{FN_PEEK, 32'h0,         8'd255, 1'b0, '0},
    '{FN_POP,  32'h0,         8'd0,   1'b0, '0},
    '{FN_DUP,  32'h0,         8'd0,   1'b0, '0},
    '{FN_PEEK, 32'h0,         8'd0,   1'b0, '0}
  };

  // stack behavior for one command, applied to the shadow copy
  function automatic stack_result_t apply_stack_op(stack_func_t f, logic [31:0] v,
                                                   logic [7:0] off);
    stack_result_t r;
    logic [31:0]   a;
    logic [31:0]   b;
    logic [31:0]   c;
    int unsigned   n;
    n = shadow_depth;
    r.read_value = '0;
    r.error = ERR_OK;
    case (f)
      FN_PUSH: begin
        if (n >= DEPTH) begin
          r.error = ERR_OVER;
        end else begin
          shadow_stack[n] = v;
          shadow_depth = n + 1;
        end
      end
      FN_POP: begin
        if (n == 0) begin
          r.error = ERR_UNDER;
        end else begin
          r.read_value = shadow_stack[n-1];
          shadow_depth = n - 1;
        end
      end
      FN_DUP: begin
        if (n == 0) begin
          r.error = ERR_UNDER;
        end else if (n >= DEPTH) begin
          r.error = ERR_OVER;
        end else begin
          shadow_stack[n] = shadow_stack[n-1];
          shadow_depth = n + 1;
        end
      end
      FN_SWAP: begin
        if (n < 2) begin
          r.error = ERR_UNDER;
        end else begin
          a = shadow_stack[n-1];
          shadow_stack[n-1] = shadow_stack[n-2];
          shadow_stack[n-2] = a;
        end
      end
      FN_ROT: begin
        // A B C (top first) becomes C A B
        if (n < 3) begin
          r.error = ERR_UNDER;
        end else begin
          a = shadow_stack[n-1];
          b = shadow_stack[n-2];
          c = shadow_stack[n-3];
          shadow_stack[n-1] = c;
          shadow_stack[n-2] = a;
          shadow_stack[n-3] = b;
        end
      end
      FN_PEEK: begin
        if (off >= n) begin
          r.error = ERR_UNDER;
        end else begin
          r.read_value = shadow_stack[n-1-off];
        end
      end
      default: begin
      end
    endcase
    r.count = CNT_W'(shadow_depth);
    return r;
  endfunction

  // drive one command and hold it until the core takes it
  task automatic issue_cmd(stack_func_t f, logic [31:0] v, logic [7:0] off, logic typed,
                           stack_result_t want);
    stack_result_t pred;
    in_func   <= f;
    in_value  <= v;
    in_offset <= off;
    start     <= 1'b1;
    do @(posedge clk); while (busy !== 1'b0);
    // transfer happened at this edge
    pred = apply_stack_op(f, v, off);
    if (typed) begin
      pending_stack_results.push_back(want);
      err_count[want.error]++;
    end else begin
      pending_stack_results.push_back(pred);
      err_count[pred.error]++;
    end
    func_count[f]++;
    if (shadow_depth > deepest) deepest = shadow_depth;
  endtask

  // sender gap: mostly none or short, now and then long
  task automatic sender_gap(bit quiet);
    int unsigned r;
    int unsigned gap;
    r = $urandom_range(0, 99);
    if (quiet || r < 50) gap = 0;
    else if (r < 90) gap = $urandom_range(1, 3);
    else gap = $urandom_range(8, 40);
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // stop sending until every outstanding result has come back
  task automatic hold_until_drained();
    start <= 1'b0;
    @(posedge clk);
    while (pending_stack_results.size() != 0) @(posedge clk);
  endtask

  function automatic logic [31:0] pick_value();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 10) return 32'h0;
    if (r < 20) return 32'hFFFF_FFFF;
    return $urandom;
  endfunction

  // peek offsets: mostly near the top, some anywhere up to the count, the rest anywhere in the offset range
  function automatic logic [7:0] pick_offset();
    int unsigned r;
    int unsigned lim;
    r = $urandom_range(0, 99);
    if (r < 60 && shadow_depth > 0) begin
      lim = (shadow_depth < 8) ? shadow_depth : 8;
      return 8'($urandom_range(0, lim - 1));
    end
    if (r < 80) begin
      lim = (shadow_depth > 255) ? 255 : shadow_depth;
      return 8'($urandom_range(0, lim));
    end
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic stack_func_t pick_func(phase_mode_t mode);
    int unsigned push_pct;
    int unsigned pop_pct;
    int unsigned r;
    int unsigned r2;
    case (mode)
      MODE_FILL: begin
        push_pct = 60;
        pop_pct  = 15;
      end
      MODE_DRAIN: begin
        push_pct = 15;
        pop_pct  = 60;
      end
      default: begin
        push_pct = 35;
        pop_pct  = 35;
      end
    endcase
    r = $urandom_range(0, 99);
    if (r < push_pct) return FN_PUSH;
    if (r < push_pct + pop_pct) return FN_POP;
    r2 = $urandom_range(0, 19);
    if (r2 < 4) return FN_DUP;
    if (r2 < 8) return FN_SWAP;
    if (r2 < 12) return FN_ROT;
    if (r2 < 18) return FN_PEEK;
    return (r2 == 18) ? FN_NOP6 : FN_NOP7;
  endfunction

  // result side: every strobe must match the oldest expectation
  always @(posedge clk) begin
    stack_result_t exp_r;
    if (rst_n === 1'b1 && out_valid === 1'b1) begin
      results_seen++;
      if (pending_stack_results.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("[%0t] result with nothing outstanding: read_value %h count %0d error %0d",
                   $realtime, out_read_value, out_count, out_error);
      end else begin
        exp_r = pending_stack_results.pop_front();
        if (out_read_value !== exp_r.read_value || out_count !== exp_r.count ||
            out_error !== exp_r.error) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("[%0t] result %0d mismatch: read_value %h/%h count %0d/%0d error %0d/%0d",
                     $realtime, results_seen, exp_r.read_value, out_read_value,
                     exp_r.count, out_count, exp_r.error, out_error);
        end
      end
    end
  end

  // timeout
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               pending_stack_results.size());
      $display("tb_data_stack_with_dup_swap_rot_core: FAIL");
      $finish;
    end
  end

  initial begin
    int unsigned  sent;
    int unsigned  phase_len;
    phase_mode_t  mode;
    bit           quiet;
    stack_func_t  f;

    rst_n     <= 1'b0;
    start     <= 1'b0;
    in_func   <= FN_NOP6;
    in_value  <= '0;
    in_offset <= '0;
    foreach (func_count[i]) func_count[i] = 0;
    foreach (err_count[i]) err_count[i] = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: empty-stack errors and each op on a small stack
    foreach (reset_rows[i]) begin
      issue_cmd(reset_rows[i].func, reset_rows[i].value, reset_rows[i].offset,
                reset_rows[i].typed, reset_rows[i].want);
      sender_gap(1'b0);
    end
    hold_until_drained();

    // fill to the top with back-to-back pushes
    while (shadow_depth < DEPTH) issue_cmd(FN_PUSH, pick_value(), 8'd0, 1'b0, '0);
    foreach (full_rows[i]) begin
      issue_cmd(full_rows[i].func, full_rows[i].value, full_rows[i].offset,
                full_rows[i].typed, full_rows[i].want);
      sender_gap(1'b0);
    end

    // random phases alternating between filling, draining and mixed traffic
    sent = 0;
    while (sent < NUM_RANDOM) begin
      mode = phase_mode_t'($urandom_range(0, 2));
      quiet = ($urandom_range(0, 3) == 0);
      phase_len = $urandom_range(40, 150);
      repeat (phase_len) begin
        f = pick_func(mode);
        issue_cmd(f, pick_value(), (f == FN_PEEK) ? pick_offset() : 8'($urandom_range(0, 255)),
                  1'b0, '0);
        sent++;
        sender_gap(quiet);
      end
      if ($urandom_range(0, 3) == 0) hold_until_drained();
    end

    hold_until_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("covered %0d commands: push %0d pop %0d dup %0d swap %0d rot %0d peek %0d unused %0d",
             results_seen, func_count[FN_PUSH], func_count[FN_POP], func_count[FN_DUP],
             func_count[FN_SWAP], func_count[FN_ROT], func_count[FN_PEEK],
             func_count[FN_NOP6] + func_count[FN_NOP7]);
    $display("deepest stack %0d words, %0d underflow and %0d overflow results, %0d mismatches",
             deepest, err_count[ERR_UNDER], err_count[ERR_OVER], mismatches);
    if (mismatches == 0 && pending_stack_results.size() == 0) begin
      $display("tb_data_stack_with_dup_swap_rot_core: PASS");
    end else begin
      $display("tb_data_stack_with_dup_swap_rot_core: FAIL");
    end
    $finish;
  end

endmodule
